@@ rtl/snt_pkg.sv @@
`timescale 1ns / 1ps
package snt_pkg;
  localparam int MaxEntries = 16;
  localparam int NameBytes  = 32;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);

  localparam logic [1:0] ReqStart  = 2'd0;
  localparam logic [1:0] ReqReport = 2'd1;
  localparam logic [1:0] ReqFinish = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [63:0] name_word3;
    logic [7:0]  name_length;
    logic signed [7:0] signal_strength;
    logic [15:0] radio_channel;
  } snt_req_t;

  typedef struct packed {
    logic [3:0]  entry_index;
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic [5:0]  out_length;
    logic signed [7:0] out_strength;
    logic [15:0] out_channel;
    logic [15:0] reports_seen;
    logic [4:0]  entries_held;
    logic        last_entry;
  } snt_rsp_t;

  // one table slot
  typedef struct packed {
    logic [255:0] name;
    logic [5:0]   len;
    logic signed [7:0] str;
    logic [15:0]  ch;
  } snt_entry_t;

  localparam int EntryW = $bits(snt_entry_t);

  function automatic logic [255:0] snt_mask(input logic [5:0] len);
    logic [255:0] m;
    m = '0;
    for (int b = 0; b < NameBytes; b++) begin
      if (6'(b) < len) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction
endpackage

@@ rtl/strongest_network_table.sv @@
`timescale 1ns / 1ps
// Strongest network table.
// Request channel: req_i is sampled when start_i is high and busy_o low.
//   A start request clears the table and the report count.
//   A report request (empty names ignored) merges one network into the table,
//   keyed by name: a known name is overwritten only by a stronger report; a
//   new one takes a free slot or displaces the first weakest entry if stronger.
//   A finish request exchange-sorts the table by falling strength and emits
//   one result per entry on rsp_o, each marked by done_o for one cycle.
// Sequence: a start is handled in the idle state; a report walks the held slots
//   through the single slot RAM, reading and checking each (StRdI, StCmpI),
//   then inserts (StIns) if no match was found. A finish runs the n*(n-1)/2
//   compare steps of the sort, reading each new left slot first (a swap adds
//   a second write), then reads out and emits each result in turn.
//   busy_o stays high while a report or finish runs; one request at a time.
// Reset: valid bits for all slots are cleared at once; a slot beyond the held
//   count reads as zero. The receiver cannot stall: each result is presented
//   for exactly one cycle.
module strongest_network_table
  import snt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  snt_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output snt_rsp_t rsp_o
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRdI   = 4'd1;  // issue read of slot i
  localparam logic [3:0] StCmpI  = 4'd2;  // match / weakest check
  localparam logic [3:0] StIns   = 4'd3;  // decide insert after walk
  localparam logic [3:0] StRdW   = 4'd4;  // read next result slot
  localparam logic [3:0] StCmpW  = 4'd5;
  localparam logic [3:0] StSrtL  = 4'd6;  // read left slot
  localparam logic [3:0] StSrtR  = 4'd7;  // read right slot
  localparam logic [3:0] StSrtC  = 4'd8;  // compare, maybe swap
  localparam logic [3:0] StSwp   = 4'd9;  // second swap write
  localparam logic [3:0] StOutR  = 4'd10;
  localparam logic [3:0] StOutE  = 4'd11;
  localparam logic [3:0] StSrtL2 = 4'd12;

  logic [3:0]      st_q, st_d;
  logic [MaxEntries-1:0] vld_q, vld_d;
  logic [CntW-1:0] held_q, held_d;
  logic [15:0]     rep_q, rep_d;
  logic [IdxW-1:0] i_q, i_d, r_q, r_d, wk_q, wk_d;
  logic signed [7:0] wks_q, wks_d;
  snt_entry_t      new_q, new_d, lft_q, lft_d;
  logic            done_q, done_d;
  snt_rsp_t        rsp_q, rsp_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  snt_entry_t      wdata, rraw, rd;

  snt_ram #(.Width(EntryW), .Depth(MaxEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rraw)
  );

  logic [IdxW-1:0] raddr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) raddr_q <= '0;
    else raddr_q <= raddr;
  end
  assign rd = vld_q[raddr_q] ? rraw : '0;

  logic [5:0] clen;
  logic [CntW-1:0] i_ext, r_ext;
  assign clen = (req_i.name_length > 8'(NameBytes)) ? 6'(NameBytes) : req_i.name_length[5:0];
  assign i_ext = CntW'(i_q);
  assign r_ext = CntW'(r_q);

  always_comb begin
    st_d = st_q; vld_d = vld_q; held_d = held_q; rep_d = rep_q;
    i_d = i_q; r_d = r_q; wk_d = wk_q; wks_d = wks_q;
    new_d = new_q; lft_d = lft_q; done_d = 1'b0; rsp_d = rsp_q;
    we = 1'b0; waddr = i_q; wdata = new_q; raddr = i_q;
    case (st_q)
      StIdle: begin
        if (start_i) begin
          case (req_i.req_type)
            ReqStart: begin
              vld_d = '0; held_d = '0; rep_d = '0;
            end
            ReqReport: begin
              if (req_i.name_length != 8'd0) begin
                new_d.name = {req_i.name_word3, req_i.name_word2,
                              req_i.name_word1, req_i.name_word0} & snt_mask(clen);
                new_d.len = clen;
                new_d.str = req_i.signal_strength;
                new_d.ch  = req_i.radio_channel;
                if (rep_q != 16'hFFFF) rep_d = rep_q + 16'd1;
                i_d = '0; wk_d = '0;
                st_d = (held_q == '0) ? StIns : StRdI;
              end
            end
            ReqFinish: begin
              i_d = '0; r_d = IdxW'(1);
              if (held_q == '0) st_d = StIdle;
              else if (held_q == CntW'(1)) st_d = StOutR;
              else st_d = StSrtL;
            end
            default: ;
          endcase
        end
      end
      StRdI: begin
        raddr = i_q; st_d = StCmpI;
      end
      StCmpI: begin
        raddr = wk_q;
        if (rd.len == new_q.len && rd.name == new_q.name) begin
          if (new_q.str > rd.str) begin
            we = 1'b1; waddr = i_q;
          end
          st_d = StIdle;
        end else begin
          if (i_q == '0) begin
            wks_d = rd.str;
          end else if (rd.str < wks_q) begin
            wk_d = i_q; wks_d = rd.str;
          end
          if (i_ext + CntW'(1) >= held_q) st_d = StIns;
          else begin
            i_d = i_q + IdxW'(1); st_d = StRdI;
          end
        end
      end
      StIns: begin
        if (held_q < CntW'(MaxEntries)) begin
          we = 1'b1; waddr = held_q[IdxW-1:0];
          vld_d[held_q[IdxW-1:0]] = 1'b1;
          held_d = held_q + CntW'(1);
        end else if (new_q.str > wks_q) begin
          we = 1'b1; waddr = wk_q;
        end
        st_d = StIdle;
      end
      StSrtL: begin
        raddr = i_q; st_d = StSrtL2;
      end
      StSrtL2: begin
        lft_d = rd; raddr = r_q; st_d = StSrtC;
      end
      StSrtR: begin
        raddr = r_q; st_d = StSrtC;
      end
      StSrtC: begin
        if (rd.str > lft_q.str) begin
          // right slot takes the old left entry now, the left slot next cycle
          we = 1'b1; waddr = r_q; wdata = lft_q;
          lft_d = rd; st_d = StSwp;
        end else begin
          st_d = StCmpW;
        end
      end
      StSwp: begin
        we = 1'b1; waddr = i_q; wdata = lft_q;
        st_d = StCmpW;
      end
      StCmpW: begin
        // advance the sort indices
        if (r_ext + CntW'(1) < held_q) begin
          r_d = r_q + IdxW'(1); st_d = StSrtR;
        end else if (i_ext + CntW'(2) < held_q) begin
          i_d = i_q + IdxW'(1); r_d = i_q + IdxW'(2); st_d = StSrtL;
        end else begin
          i_d = '0; st_d = StOutR;
        end
      end
      StRdW: begin
        raddr = i_q; st_d = StOutE;
      end
      StOutR: begin
        raddr = i_q; st_d = StOutE;
      end
      StOutE: begin
        done_d = 1'b1;
        rsp_d.entry_index  = 4'(i_q);
        rsp_d.out_word0    = rd.name[63:0];
        rsp_d.out_word1    = rd.name[127:64];
        rsp_d.out_word2    = rd.name[191:128];
        rsp_d.out_word3    = rd.name[255:192];
        rsp_d.out_length   = rd.len;
        rsp_d.out_strength = rd.str;
        rsp_d.out_channel  = rd.ch;
        rsp_d.reports_seen = rep_q;
        rsp_d.entries_held = 5'(held_q);
        rsp_d.last_entry   = (i_ext + CntW'(1) == held_q);
        if (i_ext + CntW'(1) == held_q) st_d = StIdle;
        else begin
          i_d = i_q + IdxW'(1); st_d = StRdW;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; vld_q <= '0; held_q <= '0; rep_q <= '0;
      i_q <= '0; r_q <= '0; wk_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; vld_q <= vld_d; held_q <= held_d; rep_q <= rep_d;
      i_q <= i_d; r_q <= r_d; wk_q <= wk_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wks_q <= wks_d; new_q <= new_d; lft_q <= lft_d; rsp_q <= rsp_d;
  end

  assign busy_o = (st_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= CntW'(MaxEntries))
    else $error("held count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 5'(rsp_o.entry_index) < rsp_o.entries_held)
    else $error("rank beyond held count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.last_entry) |=> !done_o)
    else $error("result after last entry");
endmodule

@@ rtl/snt_ram.sv @@
`timescale 1ns / 1ps
module snt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ dv/strongest_network_table_tb.sv @@
`timescale 1ns / 1ps
module strongest_network_table_tb;
  import snt_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 100;
  localparam logic [1:0] ReqSpare = 2'd3;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i = 1'b0;
  snt_req_t req_i = '0;
  logic     busy_o;
  logic     done_o;
  snt_rsp_t rsp_o;

  strongest_network_table u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  // predicted table
  logic [255:0]      tbl_name [MaxEntries];
  logic [5:0]        tbl_len  [MaxEntries];
  logic signed [7:0] tbl_str  [MaxEntries];
  logic [15:0]       tbl_ch   [MaxEntries];
  int                tbl_held;
  logic [15:0]       tbl_reports;

  snt_req_t pending_reqs[$];
  snt_rsp_t expected_entries[$];

  int  mismatches = 0;
  int  sender_idle_pct;
  int  idle_cycles = 0;

  function automatic logic [255:0] name_keep(input logic [5:0] len);
    logic [255:0] m;
    m = '0;
    for (int b = 0; b < NameBytes; b++)
      if (b < len) m[b*8 +: 8] = 8'hFF;
    return m;
  endfunction

  task automatic clear_predicted();
    for (int i = 0; i < MaxEntries; i++) begin
      tbl_name[i] = '0; tbl_len[i] = '0; tbl_str[i] = '0; tbl_ch[i] = '0;
    end
    tbl_held = 0;
    tbl_reports = '0;
  endtask

  task automatic put_slot(input int s, input logic [255:0] nm, input logic [5:0] ln,
                          input logic signed [7:0] st, input logic [15:0] ch);
    tbl_name[s] = nm; tbl_len[s] = ln; tbl_str[s] = st; tbl_ch[s] = ch;
  endtask

  task automatic merge_report(input snt_req_t r);
    logic [255:0] nm;
    logic [5:0]   ln;
    int           weakest;
    if (r.name_length == 0) return;
    ln = (r.name_length > NameBytes) ? 6'(NameBytes) : r.name_length[5:0];
    nm = {r.name_word3, r.name_word2, r.name_word1, r.name_word0} & name_keep(ln);
    if (tbl_reports != 16'hFFFF) tbl_reports++;
    weakest = 0;
    for (int i = 0; i < tbl_held; i++) begin
      if (tbl_len[i] == ln && tbl_name[i] == nm) begin
        if (r.signal_strength > tbl_str[i])
          put_slot(i, nm, ln, r.signal_strength, r.radio_channel);
        return;
      end
      if (tbl_str[i] < tbl_str[weakest]) weakest = i;
    end
    if (tbl_held < MaxEntries) begin
      put_slot(tbl_held, nm, ln, r.signal_strength, r.radio_channel);
      tbl_held++;
    end else if (r.signal_strength > tbl_str[weakest]) begin
      put_slot(weakest, nm, ln, r.signal_strength, r.radio_channel);
    end
  endtask

  task automatic sort_and_emit();
    logic [255:0]      tn;
    logic [5:0]        tl;
    logic signed [7:0] ts;
    logic [15:0]       tc;
    snt_rsp_t          e;
    for (int l = 0; l < tbl_held; l++)
      for (int r = l + 1; r < tbl_held; r++)
        if (tbl_str[r] > tbl_str[l]) begin
          tn = tbl_name[l]; tl = tbl_len[l]; ts = tbl_str[l]; tc = tbl_ch[l];
          put_slot(l, tbl_name[r], tbl_len[r], tbl_str[r], tbl_ch[r]);
          put_slot(r, tn, tl, ts, tc);
        end
    for (int i = 0; i < tbl_held; i++) begin
      e.entry_index  = 4'(i);
      {e.out_word3, e.out_word2, e.out_word1, e.out_word0} = tbl_name[i];
      e.out_length   = tbl_len[i];
      e.out_strength = tbl_str[i];
      e.out_channel  = tbl_ch[i];
      e.reports_seen = tbl_reports;
      e.entries_held = 5'(tbl_held);
      e.last_entry   = (i + 1 == tbl_held);
      expected_entries.push_back(e);
    end
  endtask

  task automatic predict(input snt_req_t r);
    case (r.req_type)
      ReqStart:  clear_predicted();
      ReqReport: merge_report(r);
      ReqFinish: sort_and_emit();
      default: ;
    endcase
  endtask

  function automatic snt_req_t make_req(input logic [1:0] kind, input int nlen,
                                        input int pool);
    snt_req_t r;
    r.req_type = kind;
    r.name_word0 = {$urandom, $urandom};
    r.name_word1 = {$urandom, $urandom};
    r.name_word2 = {$urandom, $urandom};
    r.name_word3 = {$urandom, $urandom};
    // small pool of names so that duplicates come up often
    if (pool > 0) begin
      r.name_word0 = 64'h5A5A_0000_0000_0000 | 64'($urandom_range(0, pool - 1));
      r.name_word1 = 64'hC3C3_1234_8765_0F0F;
      r.name_word2 = '0;
      r.name_word3 = 64'hFFFF_FFFF_0000_0001;
    end
    r.name_length = 8'(nlen);
    r.signal_strength = 8'($urandom);
    r.radio_channel = 16'($urandom);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  logic accepted;
  always @(posedge clk_i) accepted <= rst_ni && start_i && !busy_o;

  // driver
  logic hold_off;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
    end else if (!start_i || accepted) begin
      if (pending_reqs.size() > 0 && !hold_off &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        req_i   <= pending_reqs.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
        req_i   <= '0;
      end
    end
  end

  // prediction at acceptance, checking of results
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_predicted();
    end else begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start_i && !busy_o) predict(req_i);
      if (done_o) begin
        if (expected_entries.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", rsp_o);
        end else begin
          if (rsp_o !== expected_entries[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", expected_entries[0], rsp_o);
          end
          void'(expected_entries.pop_front());
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || start_i || busy_o || expected_entries.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    snt_req_t r;
    int kind;
    hold_off = 1'b1;
    sender_idle_pct = 32;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    pending_reqs.push_back(make_req(ReqFinish, 0, 0));   // empty finish
    pending_reqs.push_back(make_req(ReqStart, 0, 0));
    pending_reqs.push_back(make_req(ReqReport, 0, 0));   // empty name
    r = make_req(ReqReport, 255, 0); r.signal_strength = 8'sh80; pending_reqs.push_back(r);
    r.signal_strength = 8'sh7F; pending_reqs.push_back(r);  // same name, stronger
    r.signal_strength = 8'sh00; pending_reqs.push_back(r);  // same name, weaker
    r = make_req(ReqReport, 1, 0); r.name_word0 = '1; r.name_word1 = '1;
    r.name_word2 = '1; r.name_word3 = '1; r.radio_channel = '1; pending_reqs.push_back(r);
    r = make_req(ReqReport, 32, 0); r.name_word0 = '0; r.name_word1 = '0;
    r.name_word2 = '0; r.name_word3 = '0; r.radio_channel = '0; pending_reqs.push_back(r);
    pending_reqs.push_back(make_req(ReqSpare, 5, 0));    // unused selector
    pending_reqs.push_back(make_req(ReqFinish, 0, 0));
    for (int i = 0; i < 18; i++) pending_reqs.push_back(make_req(ReqReport, 9, 40));
    pending_reqs.push_back(make_req(ReqFinish, 0, 0));
    hold_off = 1'b0;

    // random part: a random mix of start, report, finish and spare requests, each pass closed by a finish
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = (p == 0) ? 32 : (p == 1) ? 45 : 0;
      for (int n = 0; n < 40; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 6) pending_reqs.push_back(make_req(ReqStart, 0, 0));
        else if (kind < 14) pending_reqs.push_back(make_req(ReqFinish, 0, 0));
        else if (kind < 17)
          pending_reqs.push_back(make_req(ReqSpare, $urandom_range(0, 255), 0));
        else if (kind < 22) pending_reqs.push_back(make_req(ReqReport, 0, 0));
        else if (kind < 60)
          pending_reqs.push_back(make_req(ReqReport, $urandom_range(1, 12), 24));
        else pending_reqs.push_back(make_req(ReqReport, $urandom_range(1, 255), 0));
      end
      pending_reqs.push_back(make_req(ReqFinish, 0, 0));
      while (pending_reqs.size() > 0) @(posedge clk_i);
    end

    wait_idle();
    if (mismatches == 0 && expected_entries.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
